FILE: rtl/core/dlpc_pkg.sv
// Shared types and constants for the desk lift preset controller.
`timescale 1ns / 1ps

package dlpc_pkg;

  localparam int HEIGHT_BITS    = 9;
  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int DUTY_BITS      = 8;
  localparam int STATUS_BITS    = 3;

  localparam logic [15:0] HOLD_DELAY_RST = 16'd250;
  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [15:0] OVERSHOOT_RST  = 16'd500;
  localparam logic [7:0]  DUTY_UP_RST    = 8'd255;
  localparam logic [7:0]  DUTY_DOWN_RST  = 8'd220;

  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_DELAY = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OVERSHOOT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_UP    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_DOWN  = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_NONE       = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_LOW_REJ    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_HIGH_REJ   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_SONAR      = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_LOW_SAVED  = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_HIGH_SAVED = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_REACHED    = 3'd6;
  localparam logic [STATUS_BITS-1:0] ST_CANCEL     = 3'd7;

  typedef struct packed {
    logic                   btn_raise;
    logic                   btn_lower;
    logic                   button_low_preset;
    logic                   button_high_preset;
    logic [HEIGHT_BITS-1:0] height_cm;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0]   motor_duty;
    logic                   direction_up;
    logic [STATUS_BITS-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [15:0]          hold_delay_ticks;
    logic [15:0]          long_press_ticks;
    logic [15:0]          overshoot_ticks;
    logic [DUTY_BITS-1:0] duty_up;
    logic [DUTY_BITS-1:0] duty_down;
  } cfg_t;

endpackage

FILE: rtl/core/dlpc_ctrl.sv
// Lift mode state machine, tick timer and preset store; one item per step.
`timescale 1ns / 1ps

module dlpc_ctrl #(
  parameter int TIMER_BITS = dlpc_pkg::TIMER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  dlpc_pkg::in_item_t  item,
  input  dlpc_pkg::cfg_t      cfg,
  output dlpc_pkg::out_item_t result
);
  import dlpc_pkg::*;

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  typedef enum logic [7:0] {
    M_IDLE      = 8'b0000_0001,
    M_MAN_UP    = 8'b0000_0010,
    M_MAN_DOWN  = 8'b0000_0100,
    M_HELD      = 8'b0000_1000,
    M_AUTO_UP   = 8'b0001_0000,
    M_AUTO_DOWN = 8'b0010_0000,
    M_OVER_UP   = 8'b0100_0000,
    M_OVER_DOWN = 8'b1000_0000
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [TIMER_BITS-1:0]  timer_r, timer_nxt, timer_inc;
  logic [HEIGHT_BITS-1:0] low_r, low_nxt, high_r, high_nxt;
  logic [3:0]             prev_r, btn, rise;
  logic                   is_high_r, is_high_nxt;
  logic                   drv_up, drv_dn;
  logic [STATUS_BITS-1:0] status;
  logic [HEIGHT_BITS-1:0] h;
  logic                   h_zero;
  logic [CW-1:0]          t_cur, t_inc, hold_w, long_w, over_w;
  logic                   own_held, arrived;

  assign btn  = {item.button_high_preset, item.button_low_preset,
                 item.btn_lower, item.btn_raise};
  assign rise = btn & ~prev_r;
  assign h    = item.height_cm;
  assign h_zero = (h == '0);

  assign timer_inc = (timer_r == {TIMER_BITS{1'b1}}) ? timer_r : timer_r + 1'b1;
  assign t_cur  = CW'(timer_r);
  assign t_inc  = CW'(timer_inc);
  assign hold_w = CW'(cfg.hold_delay_ticks);
  assign long_w = CW'(cfg.long_press_ticks);
  assign over_w = CW'(cfg.overshoot_ticks);

  always_comb begin
    mode_nxt    = mode_r;
    timer_nxt   = timer_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    is_high_nxt = is_high_r;
    drv_up      = 1'b0;
    drv_dn      = 1'b0;
    status      = ST_NONE;
    own_held    = is_high_r ? btn[3] : btn[2];
    arrived     = (mode_r == M_AUTO_UP) ? (h >= high_r) : (h <= low_r);
    unique case (mode_r)
      M_IDLE: begin
        if (rise[0]) begin
          mode_nxt  = M_MAN_UP;
          timer_nxt = '0;
          drv_up    = (hold_w == '0);
        end else if (rise[1]) begin
          mode_nxt  = M_MAN_DOWN;
          timer_nxt = '0;
          drv_dn    = (hold_w == '0);
        end else if (rise[2]) begin
          mode_nxt    = M_HELD;
          timer_nxt   = '0;
          is_high_nxt = 1'b0;
        end else if (rise[3]) begin
          mode_nxt    = M_HELD;
          timer_nxt   = '0;
          is_high_nxt = 1'b1;
        end
      end
      M_MAN_UP: begin
        if (!btn[0] || btn[1]) begin
          mode_nxt = M_IDLE;
        end else begin
          timer_nxt = timer_inc;
          drv_up    = (t_inc >= hold_w);
        end
      end
      M_MAN_DOWN: begin
        if (!btn[1] || btn[0]) begin
          mode_nxt = M_IDLE;
        end else begin
          timer_nxt = timer_inc;
          drv_dn    = (t_inc >= hold_w);
        end
      end
      M_HELD: begin
        timer_nxt = timer_inc;
        if (!own_held) begin
          mode_nxt = M_IDLE;
          if (t_inc >= long_w) begin
            if (!is_high_r) begin
              if (h >= high_r) begin
                status = ST_LOW_REJ;
              end else begin
                low_nxt = h;
                status  = ST_LOW_SAVED;
              end
            end else begin
              if (h <= low_r) begin
                status = ST_HIGH_REJ;
              end else begin
                high_nxt = h;
                status   = ST_HIGH_SAVED;
              end
            end
          end else if (h_zero) begin
            status = ST_SONAR;
          end else if (!is_high_r) begin
            if (h > low_r) begin
              mode_nxt = M_AUTO_DOWN;
              drv_dn   = 1'b1;
            end else begin
              status = ST_REACHED;
            end
          end else begin
            if (h < high_r) begin
              mode_nxt = M_AUTO_UP;
              drv_up   = 1'b1;
            end else begin
              status = ST_REACHED;
            end
          end
        end
      end
      M_AUTO_UP, M_AUTO_DOWN: begin
        if (h_zero) begin
          mode_nxt = M_IDLE;
          status   = ST_SONAR;
        end else if (arrived) begin
          if (over_w == '0) begin
            mode_nxt = M_IDLE;
            status   = ST_REACHED;
          end else begin
            mode_nxt  = (mode_r == M_AUTO_UP) ? M_OVER_UP : M_OVER_DOWN;
            timer_nxt = TIMER_BITS'(1);
            drv_up    = (mode_r == M_AUTO_UP);
            drv_dn    = (mode_r == M_AUTO_DOWN);
          end
        end else if (rise[0] || rise[1]) begin
          mode_nxt = M_IDLE;
          status   = ST_CANCEL;
        end else begin
          drv_up = (mode_r == M_AUTO_UP);
          drv_dn = (mode_r == M_AUTO_DOWN);
        end
      end
      M_OVER_UP, M_OVER_DOWN: begin
        if (t_cur >= over_w) begin
          mode_nxt = M_IDLE;
          status   = ST_REACHED;
        end else begin
          drv_up    = (mode_r == M_OVER_UP);
          drv_dn    = (mode_r == M_OVER_DOWN);
          timer_nxt = timer_inc;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase
    if ((mode_nxt == M_MAN_UP || mode_nxt == M_MAN_DOWN) && h_zero) begin
      status = ST_SONAR;
    end
  end

  always_comb begin
    result.motor_duty   = drv_up ? cfg.duty_up : (drv_dn ? cfg.duty_down : '0);
    result.direction_up = drv_up;
    result.status       = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      timer_r   <= '0;
      low_r     <= '0;
      high_r    <= '0;
      prev_r    <= '0;
      is_high_r <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      timer_r   <= timer_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      prev_r    <= btn;
      is_high_r <= is_high_nxt;
    end
  end

endmodule

FILE: rtl/core/desk_lift_preset_controller.sv
// Top level: configuration registers, input stage and result register.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | in_item (button levels, height_cm)
//   out_    | output    | out_valid/out_stall | out_item (motor_duty, direction_up, status)
//   cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low; an accepted item is held in the
// input stage, and the result register is loaded from it when that stage advances.
// While a result waits on out_stall the input stage takes one item, then in_stall rises.
// Reset is synchronous on rst_n: mode idle, presets zero, registers at defaults.
`timescale 1ns / 1ps

module desk_lift_preset_controller #(
  parameter int TIMER_BITS = dlpc_pkg::TIMER_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dlpc_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output dlpc_pkg::out_item_t                   out_item,
  input  logic                                  cfg_we,
  input  logic [dlpc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [dlpc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import dlpc_pkg::*;

  cfg_t      cfg_r;
  logic      stg_valid_r;
  in_item_t  stg_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;
  logic      in_take;

  assign advance  = stg_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = stg_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  dlpc_ctrl #(
    .TIMER_BITS(TIMER_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (stg_item_r),
    .cfg   (cfg_r),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_delay_ticks <= HOLD_DELAY_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
      cfg_r.overshoot_ticks  <= OVERSHOOT_RST;
      cfg_r.duty_up          <= DUTY_UP_RST;
      cfg_r.duty_down        <= DUTY_DOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLD_DELAY: cfg_r.hold_delay_ticks <= cfg_wdata;
        CFG_LONG_PRESS: cfg_r.long_press_ticks <= cfg_wdata;
        CFG_OVERSHOOT:  cfg_r.overshoot_ticks  <= cfg_wdata;
        CFG_DUTY_UP:    cfg_r.duty_up          <= cfg_wdata[DUTY_BITS-1:0];
        CFG_DUTY_DOWN:  cfg_r.duty_down        <= cfg_wdata[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        stg_valid_r <= 1'b1;
      end else if (advance) begin
        stg_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule
